>>> sv/ln1p_pkg.sv
// ----------------------------------------------------------------------------
// ln1p_pkg
// Shared widths, word types and control bundles for the ln(1+x) series core.
// ----------------------------------------------------------------------------
package ln1p_pkg;

  localparam int FRAC_BITS = 30;
  localparam int MAX_TERMS = 1024;
  localparam int X_W       = 32;
  localparam int N_W       = 11;
  localparam int SUM_W     = 40;
  localparam int MAG_W     = FRAC_BITS;
  localparam int DIV_STEPS = MAG_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic signed [X_W-1:0] x_value;
    logic [N_W-1:0]        term_count;
  } in_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] series_sum;
    logic                    range_error;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic acc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic finish;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

>>> sv/ln1p_taylor_series_core.sv
// ----------------------------------------------------------------------------
// ln1p_taylor_series_core
// Taylor partial sum of ln(1+x), Q1.30 in, Q9.30 out, one result per word.
// Terms are summed up to the clamped count, or fewer once the power truncates
// to zero; each term is a check, a bit-serial divide and an add, the divide
// done by the one-bit-per-cycle restoring divider. An error word skips the
// terms. One word in flight; the next is accepted once the result is
// registered, and a finished word waits until the output register is free.
// Synchronous reset returns the sequencer to idle and empties the output.
// ----------------------------------------------------------------------------
module ln1p_taylor_series_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ln1p_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ln1p_pkg::out_word_t out_data
);
  import ln1p_pkg::*;

  cmd_t    cmd;
  status_t status;

  ln1p_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ln1p_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sv/ln1p_ctrl.sv
// ----------------------------------------------------------------------------
// ln1p_ctrl
// Sequencer: per term, one check state, a bit-serial divide, one accumulate.
// ----------------------------------------------------------------------------
module ln1p_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ln1p_pkg::status_t status,
  output ln1p_pkg::cmd_t    cmd
);
  import ln1p_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_DIV   = 5'b00100,
    S_ACC   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.finish) begin
          state_next = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_CHECK;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> sv/ln1p_dpath.sv
// ----------------------------------------------------------------------------
// ln1p_dpath
// Power register and multiplier, restoring divider, accumulator, output word.
// ----------------------------------------------------------------------------
module ln1p_dpath (
  input  logic                clk,
  input  logic                rst,
  input  ln1p_pkg::in_word_t  in_data,
  input  ln1p_pkg::cmd_t      cmd,
  output ln1p_pkg::status_t   status,
  output logic                out_valid,
  input  logic                out_ready,
  output ln1p_pkg::out_word_t out_data
);
  import ln1p_pkg::*;

  logic [X_W-1:0]          in_mag;
  logic                    in_err;
  logic [N_W-1:0]          in_n;

  logic [MAG_W-1:0]        x_mag;
  logic                    x_neg;
  logic                    err;
  logic [N_W-1:0]          n;
  logic [N_W-1:0]          idx;
  logic [MAG_W-1:0]        p_mag;
  logic                    p_neg;
  logic [2*MAG_W-1:0]      prod;
  logic signed [SUM_W-1:0] sum;

  logic [MAG_W-1:0]        quo;
  logic [N_W-1:0]          rem;
  logic [CNT_W-1:0]        cnt;
  logic [N_W:0]            trial;
  logic                    take;
  logic                    sub;
  logic signed [SUM_W-1:0] term;

  assign in_mag = in_data.x_value[X_W-1] ? (~in_data.x_value + 1'b1) : in_data.x_value;
  assign in_err = (in_mag >= (X_W'(1) << FRAC_BITS)) || (in_data.term_count == '0);
  assign in_n   = (in_data.term_count > N_W'(MAX_TERMS)) ? N_W'(MAX_TERMS)
                                                          : in_data.term_count;

  assign trial = {rem, quo[MAG_W-1]};
  assign take  = (trial >= {1'b0, idx});
  assign sub   = p_neg ^ ~idx[0];
  assign term  = SUM_W'(quo);

  always_ff @(posedge clk) begin
    prod <= p_mag * x_mag;
    if (cmd.load) begin
      x_mag <= in_mag[MAG_W-1:0];
      x_neg <= in_data.x_value[X_W-1];
      err   <= in_err;
      n     <= in_n;
      idx   <= N_W'(1);
      p_mag <= in_mag[MAG_W-1:0];
      p_neg <= in_data.x_value[X_W-1];
      sum   <= '0;
    end
    if (cmd.div_start) begin
      quo <= p_mag;
      rem <= '0;
      cnt <= CNT_W'(DIV_STEPS - 1);
    end
    if (cmd.div_step) begin
      if (take) begin
        rem <= N_W'(trial - {1'b0, idx});
      end else begin
        rem <= trial[N_W-1:0];
      end
      quo <= {quo[MAG_W-2:0], take};
      cnt <= cnt - 1'b1;
    end
    if (cmd.acc) begin
      sum   <= sub ? (sum - term) : (sum + term);
      p_mag <= prod[2*MAG_W-1:MAG_W];
      p_neg <= p_neg ^ x_neg;
      idx   <= idx + 1'b1;
    end
    if (cmd.emit) begin
      out_data.series_sum  <= err ? '0 : sum;
      out_data.range_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.finish   = err || (idx > n) || (p_mag == '0);
  assign status.div_last = (cnt == '0);
  assign status.out_free = !out_valid || out_ready;

endmodule

>>> tb/sv/tb_ln1p_taylor_series_core.sv
// ----------------------------------------------------------------------------
// tb_ln1p_taylor_series_core
// Self-checking bench for the ln(1+x) Taylor series core. Directed words hit
// the ends of the argument range, the out-of-range codes, a zero term count,
// the clamp above the maximum term count and a power that dies out early.
// Random words follow, mostly legal arguments with short series. A model in
// the bench predicts every result word, and the words are checked in order
// under random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_ln1p_taylor_series_core;
  import ln1p_pkg::*;

  class series_checker;
    out_word_t expected_sums[$];
    int        mismatch_count = 0;

    function out_word_t ln1p_partial_sum(in_word_t w);
      logic [63:0] x_mag, p_mag, n_terms, i, t;
      logic        x_neg, p_neg;
      longint      acc, sum_hi;
      out_word_t   r;
      r = '0;
      x_neg = w.x_value[X_W-1];
      x_mag = {32'b0, w.x_value};
      if (x_neg) x_mag = (64'd1 << X_W) - x_mag;
      n_terms = 64'(w.term_count);
      if (x_mag >= (64'd1 << FRAC_BITS) || n_terms == 0) begin
        r.range_error = 1'b1;
        return r;
      end
      if (n_terms > 64'(MAX_TERMS)) n_terms = 64'(MAX_TERMS);
      p_mag = x_mag;
      p_neg = x_neg;
      acc = 0;
      for (i = 1; i <= n_terms && p_mag != 0; i++) begin
        t = p_mag / i;
        if (p_neg ^ ~i[0]) acc -= longint'(t);
        else acc += longint'(t);
        p_mag = (p_mag * x_mag) >> FRAC_BITS;
        p_neg = p_neg ^ x_neg;
      end
      sum_hi = (longint'(1) <<< (SUM_W - 1)) - 1;
      if (acc > sum_hi) acc = sum_hi;
      if (acc < -sum_hi - 1) acc = -sum_hi - 1;
      r.series_sum = acc[SUM_W-1:0];
      return r;
    endfunction

    function void note_argument(in_word_t w);
      expected_sums.push_back(ln1p_partial_sum(w));
    endfunction

    function void check_sum(out_word_t got);
      out_word_t want;
      if (expected_sums.size() == 0) begin
        $error("unexpected word: series_sum %0d range_error %0b",
               got.series_sum, got.range_error);
        mismatch_count++;
        return;
      end
      want = expected_sums.pop_front();
      if (got.series_sum !== want.series_sum) begin
        $error("series_sum: expected %0d, actual %0d", want.series_sum, got.series_sum);
        mismatch_count++;
      end
      if (got.range_error !== want.range_error) begin
        $error("range_error: expected %0b, actual %0b",
               want.range_error, got.range_error);
        mismatch_count++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      steady_phase;

  series_checker sums = new;

  ln1p_taylor_series_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("** ln1p_taylor_series_core: FAILED **");
    $finish;
  end

  function automatic in_word_t arg_word(logic signed [X_W-1:0] x, logic [N_W-1:0] n);
    in_word_t w;
    w.x_value    = x;
    w.term_count = n;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    gap = 0;
    if (!steady_phase) begin
      while ($urandom_range(99) < 11) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    sums.note_argument(w);
  endtask

  // receiver: random back-pressure plus one long stall to fill the core
  initial begin
    int hold_left;
    int results_seen;
    hold_left    = 0;
    results_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
        sums.check_sum(out_data);
        results_seen++;
        if (results_seen == 15) hold_left = 400;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= steady_phase || ($urandom_range(99) >= 11);
      end
    end
  end

  initial begin
    in_word_t               directed[$];
    in_word_t               w;
    logic [31:0]            mag;
    logic signed [X_W-1:0]  xs;
    int                     k;
    int                     pick;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_data      <= '0;
    steady_phase <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(arg_word(32'sh0000_0000, 1));
    directed.push_back(arg_word(32'sh0000_0000, 2047));
    directed.push_back(arg_word(32'sh3FFF_FFFF, 1));
    directed.push_back(arg_word(32'sh3FFF_FFFF, 2));
    directed.push_back(arg_word(32'sh3FFF_FFFF, 1024));
    directed.push_back(arg_word(-32'sh3FFF_FFFF, 1));
    directed.push_back(arg_word(-32'sh3FFF_FFFF, 3));
    directed.push_back(arg_word(-32'sh3FFF_FFFF, 2047));
    directed.push_back(arg_word(32'sh2000_0000, 1024));
    directed.push_back(arg_word(-32'sh2000_0000, 1500));
    directed.push_back(arg_word(32'sh4000_0000, 5));
    directed.push_back(arg_word(-32'sh4000_0000, 5));
    directed.push_back(arg_word(32'sh8000_0000, 5));
    directed.push_back(arg_word(32'sh7FFF_FFFF, 7));
    directed.push_back(arg_word(32'sh0000_0001, 2047));
    directed.push_back(arg_word(-32'sh0000_0001, 3));
    directed.push_back(arg_word(32'sh2000_0000, 0));
    directed.push_back(arg_word(32'sh8000_0000, 0));
    directed.push_back(arg_word(32'sh0012_D687, 12));
    directed.push_back(arg_word(-32'sh3FFF_FFFF, 48));
    directed.push_back(arg_word(32'sh3FFF_FFFF, 1025));
    foreach (directed[d]) send_word(directed[d]);

    for (k = 0; k < 80; k++) begin
      steady_phase <= (k >= 40 && k < 70);
      pick = $urandom_range(99);
      if (k % 25 == 12) begin
        // near one with a long series: slow but legal
        xs = 32'h4000_0000 - $urandom_range(1, 64);
        if ($urandom_range(1)) xs = -xs;
        w = arg_word(xs, N_W'($urandom_range(1000, 2047)));
      end else if (pick < 12) begin
        mag = $urandom;
        mag[31:30] = $urandom_range(1) ? 2'b01 : 2'b10;
        w = arg_word(mag, N_W'($urandom_range(2047)));
      end else if (pick < 20) begin
        w = arg_word($urandom, 0);
      end else if (pick < 32) begin
        // tiny argument: power vanishes after the first term
        xs = $urandom_range(32'h7FFF);
        if ($urandom_range(1)) xs = -xs;
        w = arg_word(xs, N_W'($urandom_range(1, 2047)));
      end else begin
        if ($urandom_range(3) == 0) mag = 32'h4000_0000 - $urandom_range(1, 4095);
        else mag = $urandom_range(32'h3FFF_FFFF);
        xs = mag;
        if ($urandom_range(1)) xs = -xs;
        w = arg_word(xs, N_W'($urandom_range(1, 48)));
      end
      send_word(w);
    end
    in_valid     <= 1'b0;
    steady_phase <= 1'b0;

    while (sums.expected_sums.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sums.mismatch_count == 0) begin
      $display("** ln1p_taylor_series_core: PASSED **");
    end else begin
      $display("** ln1p_taylor_series_core: FAILED **");
    end
    $finish;
  end

endmodule
